/* src/thermal_throttle_level_fsm_defines.svh */
// Assertion macros shared by the thermal throttle RTL
`ifndef THERMAL_THROTTLE_LEVEL_FSM_DEFINES_SVH
`define THERMAL_THROTTLE_LEVEL_FSM_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TTL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("thermal throttle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thermal throttle check failed");

`endif

/* src/ttl_pkg.sv */
// Types, constants and helpers of the thermal throttle block
package ttl_pkg;

  localparam int unsigned TempW    = 10;
  localparam int unsigned FreqW    = 22;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LvlW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumTimed = 3;

  typedef logic [TempW-1:0] temp_t;
  typedef logic [FreqW-1:0] freq_t;
  typedef logic [TimeW-1:0] ms_t;
  typedef logic [LvlW-1:0]  level_t;

  // throttle levels
  localparam level_t LVL_NONE = 2'd0;
  localparam level_t LVL_LOW  = 2'd1;
  localparam level_t LVL_MID  = 2'd2;
  localparam level_t LVL_MAX  = 2'd3;

  // frequency selects (restore or per-level table entry)
  localparam level_t SEL_RESTORE = 2'd0;
  localparam level_t SEL_LOW     = 2'd1;
  localparam level_t SEL_MID     = 2'd2;
  localparam level_t SEL_MAX     = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EMERG_TEMP     = 3'd0,
    REG_LOW_TRIP_TEMP  = 3'd1,
    REG_LOW_CLEAR_TEMP = 3'd2,
    REG_MID_TRIP_TEMP  = 3'd3,
    REG_MID_CLEAR_TEMP = 3'd4,
    REG_MAX_TRIP_TEMP  = 3'd5,
    REG_MAX_CLEAR_TEMP = 3'd6,
    REG_FALLBACK_FREQ  = 3'd7
  } cfg_reg_e;

  // input word
  typedef struct packed {
    temp_t temperature;
    logic  sensor_ok;
    freq_t current_max_freq;
    ms_t   now_ms;
  } in_word_t;

  // result word
  typedef struct packed {
    level_t level;
    logic   apply_limit;
    level_t freq_select;
    freq_t  restore_freq;
    logic   shutdown_request;
    logic   online_all_request;
    ms_t    time_low_ms;
    ms_t    time_mid_ms;
    ms_t    time_max_ms;
  } out_word_t;

  // configuration write word
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [FreqW-1:0]   value;
  } cfg_word_t;

  // configuration register file contents
  typedef struct packed {
    temp_t emerg_temp;
    temp_t low_trip_temp;
    temp_t low_clear_temp;
    temp_t mid_trip_temp;
    temp_t mid_clear_temp;
    temp_t max_trip_temp;
    temp_t max_clear_temp;
    freq_t fallback_freq;
  } cfg_regs_t;

  // level tracking state
  typedef struct packed {
    level_t level;
    freq_t  saved_max_freq;
    ms_t    interval_start;
    logic   interval_open;
    level_t interval_level;
  } thr_state_t;

  // decision stage result, handed to the counter stage
  typedef struct packed {
    level_t level;
    logic   apply;
    level_t sel;
    freq_t  restore;
    logic   shut;
    logic   online;
    logic   close;
    level_t close_level;
    ms_t    delta;
  } step_res_t;

  // saturating 32-bit add
  function automatic ms_t sat_add(ms_t a, ms_t b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

endpackage

/* src/ttl_stream_if.sv */
// Valid/ready channel carrying one word of a given type
interface ttl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/ttl_step.sv */
// Level decision for one sample: thresholds, restore value, interval bookkeeping
module ttl_step (
  input  ttl_pkg::cfg_regs_t  cfg_i,
  input  ttl_pkg::in_word_t   sample_i,
  input  ttl_pkg::thr_state_t state_i,
  output ttl_pkg::thr_state_t state_o,
  output ttl_pkg::step_res_t  res_o
);
  import ttl_pkg::*;

  temp_t  t;
  level_t lvl_in;
  level_t lvl_new;
  logic   shut;
  logic   apply;
  level_t sel;
  logic   online;
  freq_t  saved_new;

  // level rules, first match wins
  always_comb begin
    t       = sample_i.temperature;
    shut    = (t >= cfg_i.emerg_temp);
    lvl_in  = shut ? LVL_MAX : state_i.level;
    apply   = 1'b0;
    sel     = SEL_RESTORE;
    online  = 1'b0;
    lvl_new = lvl_in;
    if (t >= cfg_i.low_trip_temp && t < cfg_i.mid_trip_temp && lvl_in == LVL_NONE) begin
      apply = 1'b1; sel = SEL_LOW; lvl_new = LVL_LOW;
    end else if (t < cfg_i.low_clear_temp && lvl_in != LVL_NONE) begin
      apply = 1'b1; sel = SEL_RESTORE; online = 1'b1; lvl_new = LVL_NONE;
    end else if (t >= cfg_i.mid_trip_temp && t < cfg_i.max_trip_temp && lvl_in < LVL_MID) begin
      apply = 1'b1; sel = SEL_MID; lvl_new = LVL_MID;
    end else if (t < cfg_i.mid_clear_temp && lvl_in > LVL_LOW) begin
      apply = 1'b1; sel = SEL_LOW; lvl_new = LVL_LOW;
    end else if (t >= cfg_i.max_trip_temp) begin
      apply = 1'b1; sel = SEL_MAX; lvl_new = LVL_MAX;
    end else if (t < cfg_i.max_clear_temp && lvl_in == LVL_MAX) begin
      apply = 1'b1; sel = SEL_MID; lvl_new = LVL_MID;
    end
  end

  // unthrottled maximum is tracked while at level 0
  assign saved_new = (lvl_in == LVL_NONE) ? sample_i.current_max_freq
                                          : state_i.saved_max_freq;

  // next state: a new interval opens whenever the level is nonzero
  always_comb begin
    state_o.level          = lvl_new;
    state_o.saved_max_freq = saved_new;
    state_o.interval_open  = (lvl_new != LVL_NONE);
    state_o.interval_level = (lvl_new != LVL_NONE) ? lvl_new : state_i.interval_level;
    state_o.interval_start = (lvl_new != LVL_NONE) ? sample_i.now_ms
                                                   : state_i.interval_start;
  end

  // result word plus the closed interval for the counter stage
  always_comb begin
    res_o.level       = lvl_new;
    res_o.apply       = apply;
    res_o.sel         = sel;
    res_o.restore     = (saved_new != '0) ? saved_new : cfg_i.fallback_freq;
    res_o.shut        = shut;
    res_o.online      = online;
    res_o.close       = state_i.interval_open && (state_i.interval_level != LVL_NONE);
    res_o.close_level = state_i.interval_level;
    res_o.delta       = sample_i.now_ms - state_i.interval_start;
  end

endmodule

/* src/thermal_throttle_level_fsm.sv */
// Top level of the multi-level thermal throttle with hysteresis
//
//  channel | dir | word        | accepted when
//  --------+-----+-------------+-------------------------
//  in_i    | in  | in_word_t   | in_i.valid  && in_i.ready
//  out_o   | out | out_word_t  | out_o.valid && out_o.ready
//  cfg_i   | in  | cfg_word_t  | cfg_i.valid (ready always high)
//
// One sample per cycle while the output is not stalled; each sample passes the
// input register, the decision stage and the counter/output stage in turn.
// The level state loops once per cycle in the decision stage, the time
// counters once per cycle in the output stage, each only when a valid word moves.
// Samples with sensor_ok low are taken and dropped at the input register.
// Reset clears all control state and loads the threshold reset values.
// A stalled output holds back stage by stage; a stage takes a word when empty
// or when the stage after it moves.
`include "thermal_throttle_level_fsm_defines.svh"

module thermal_throttle_level_fsm (
  input logic clk_i,
  input logic rst_ni,
  ttl_stream_if.sink   in_i,
  ttl_stream_if.source out_o,
  ttl_stream_if.sink   cfg_i
);
  import ttl_pkg::*;

  cfg_regs_t  cfg_q;
  in_word_t   s1_q;
  logic       s1_v_q;
  step_res_t  s2_q;
  step_res_t  res_d;
  logic       s2_v_q;
  logic       out_v_q;
  thr_state_t state_q;
  thr_state_t state_d;
  ms_t        time_q [NumTimed];
  ms_t        time_d [NumTimed];
  level_t     lvl_q;
  logic       apply_q;
  level_t     sel_q;
  freq_t      restore_q;
  logic       shut_q;
  logic       online_q;
  logic       s1_ready;
  logic       s2_ready;
  logic       s3_ready;
  logic       in_fire;

  // stage handshakes
  assign s3_ready   = !out_v_q || out_o.ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_fire    = in_i.valid && s1_ready;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emerg_temp     <= '1;
      cfg_q.low_trip_temp  <= '1;
      cfg_q.low_clear_temp <= '0;
      cfg_q.mid_trip_temp  <= '1;
      cfg_q.mid_clear_temp <= '0;
      cfg_q.max_trip_temp  <= '1;
      cfg_q.max_clear_temp <= '0;
      cfg_q.fallback_freq  <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_EMERG_TEMP:     cfg_q.emerg_temp     <= cfg_i.data.value[TempW-1:0];
        REG_LOW_TRIP_TEMP:  cfg_q.low_trip_temp  <= cfg_i.data.value[TempW-1:0];
        REG_LOW_CLEAR_TEMP: cfg_q.low_clear_temp <= cfg_i.data.value[TempW-1:0];
        REG_MID_TRIP_TEMP:  cfg_q.mid_trip_temp  <= cfg_i.data.value[TempW-1:0];
        REG_MID_CLEAR_TEMP: cfg_q.mid_clear_temp <= cfg_i.data.value[TempW-1:0];
        REG_MAX_TRIP_TEMP:  cfg_q.max_trip_temp  <= cfg_i.data.value[TempW-1:0];
        REG_MAX_CLEAR_TEMP: cfg_q.max_clear_temp <= cfg_i.data.value[TempW-1:0];
        REG_FALLBACK_FREQ:  cfg_q.fallback_freq  <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // input register; invalid sensor words die here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_fire && in_i.data.sensor_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_q <= in_i.data;
    end
  end

  // decision stage
  ttl_step u_step (
    .cfg_i    (cfg_q),
    .sample_i (s1_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      state_q <= '0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_q <= res_d;
    end
  end

  // time counters: one saturating adder per nonzero level
  always_comb begin
    for (int i = 0; i < NumTimed; i++) begin
      time_d[i] = (s2_q.close && s2_q.close_level == LvlW'(i + 1))
                  ? sat_add(time_q[i], s2_q.delta) : time_q[i];
    end
  end

  // output stage; the counters double as the result's time fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      for (int i = 0; i < NumTimed; i++) begin
        time_q[i] <= '0;
      end
    end else if (s3_ready) begin
      out_v_q <= s2_v_q;
      if (s2_v_q) begin
        for (int i = 0; i < NumTimed; i++) begin
          time_q[i] <= time_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      lvl_q     <= s2_q.level;
      apply_q   <= s2_q.apply;
      sel_q     <= s2_q.sel;
      restore_q <= s2_q.restore;
      shut_q    <= s2_q.shut;
      online_q  <= s2_q.online;
    end
  end

  // result word
  assign out_o.valid = out_v_q;
  always_comb begin
    out_o.data.level              = lvl_q;
    out_o.data.apply_limit        = apply_q;
    out_o.data.freq_select        = sel_q;
    out_o.data.restore_freq       = restore_q;
    out_o.data.shutdown_request   = shut_q;
    out_o.data.online_all_request = online_q;
    out_o.data.time_low_ms        = time_q[0];
    out_o.data.time_mid_ms        = time_q[1];
    out_o.data.time_max_ms        = time_q[2];
  end

  // checks
  `TTL_ASSERT_IMP(a_interval_tracks_level, 1'b1, state_q.interval_open == (state_q.level != LVL_NONE))
  `TTL_ASSERT_IMP(a_online_means_restore, out_v_q && online_q, lvl_q == LVL_NONE && apply_q && sel_q == SEL_RESTORE)
  `TTL_ASSERT_IMP(a_no_apply_no_select, out_v_q && !apply_q, sel_q == SEL_RESTORE)
  `TTL_ASSERT_NEXT(a_low_time_monotonic, 1'b1, time_q[0] >= $past(time_q[0]))
  `TTL_ASSERT_NEXT(a_stall_holds_times, out_v_q && !out_o.ready, $stable(time_q[0]) && $stable(time_q[1]) && $stable(time_q[2]))

endmodule
